// ===== src/nearest_greater_left_stack_macros.svh =====
// assertion macros for the nearest-greater stack block
// used at the end of nearest_greater_left_stack; expects clk and rst_n in scope
`ifndef NEAREST_GREATER_LEFT_STACK_MACROS_SVH
`define NEAREST_GREATER_LEFT_STACK_MACROS_SVH

// same-cycle implication
`define NGL_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NGL_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/nglstk_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the nearest-greater stack block
// no dependencies; imported by nglstk_cell, nearest_greater_left_stack and the bench
package nglstk_pkg;

  localparam int VALUE_W     = 32;
  localparam int STACK_DEPTH = 64;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  typedef struct packed {
    logic signed [VALUE_W-1:0] sample;
    logic                      restart;
  } in_word_t;

  typedef struct packed {
    logic                      found;
    logic signed [VALUE_W-1:0] nearest_greater;
    logic                      truncated;
  } out_word_t;

  // shift command shared by every cell of the stack
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

endpackage

// ===== src/nearest_greater_left_stack.sv =====
`timescale 1ns / 1ps
// Nearest greater value to the left. The stack is a row of 64 shift cells
// with the top in cell 0; on each shift the whole row either pops one entry
// (shifts toward the top) or pushes the new word (shifts away, the oldest
// entry falls off the far end when full and truncated is raised). An item
// pops every entry not greater than it and then pushes; the next word is
// accepted at the push, and every entry is popped at most once. The result
// sits in an output register; the push waits while that register is stalled.
// depends on nglstk_pkg, nglstk_cell and nearest_greater_left_stack_macros.svh
module nearest_greater_left_stack (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  nglstk_pkg::in_word_t  in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output nglstk_pkg::out_word_t out_word
);
  import nglstk_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                      state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      ovf_r, ovf_nxt;
  logic signed [VALUE_W-1:0] cur_sample_r;
  logic                      out_valid_r;
  out_word_t                 out_word_r;

  logic signed [VALUE_W-1:0] cell_q [STACK_DEPTH];
  shift_ctl_t                ctl;

  logic in_fire, has_top, full, pop_go, push_go, out_free;

  assign has_top  = (cnt_r != '0);
  assign full     = (cnt_r == CNT_W'(STACK_DEPTH));
  assign out_free = !out_valid_r || !out_stall;
  assign pop_go   = (state_r == ST_RUN) && has_top && (cell_q[0] <= cur_sample_r);
  assign push_go  = (state_r == ST_RUN) && !pop_go && out_free;
  assign in_stall = (state_r == ST_RUN) && !push_go;
  assign in_fire  = in_valid && !in_stall;

  assign ctl.push = push_go;
  assign ctl.pop  = pop_go;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] above, below;
    if (i == 0) begin : g_top
      assign above = cur_sample_r;
    end else begin : g_mid
      assign above = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_end
      assign below = cell_q[i];
    end else begin : g_inner
      assign below = cell_q[i+1];
    end
    nglstk_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .from_top   (above),
      .from_bottom(below),
      .q          (cell_q[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    if (in_fire) begin
      state_nxt = ST_RUN;
    end else if (push_go) begin
      state_nxt = ST_IDLE;
    end
  end

  // a restart on the incoming word wins over the push finishing the last one
  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    priority if (in_fire && in_word.restart) begin
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (pop_go) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end else if (push_go) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      if (push_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_sample_r <= in_word.sample;
    end
    if (push_go) begin
      out_word_r.found           <= has_top;
      out_word_r.nearest_greater <= has_top ? cell_q[0] : '0;
      out_word_r.truncated       <= ovf_r | full;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`include "nearest_greater_left_stack_macros.svh"

  `NGL_CHECK_NOW(a_cnt_range, 1'b1, cnt_r <= CNT_W'(STACK_DEPTH), "stack count past depth")
  `NGL_CHECK_NOW(a_no_idle_shift, state_r == ST_IDLE, !pop_go && !push_go, "shift while idle")
  `NGL_CHECK_NEXT(a_pop_dec, pop_go, cnt_r == $past(cnt_r) - CNT_W'(1), "pop lost count")
  `NGL_CHECK_NEXT(a_ovf_set, push_go && full && !(in_fire && in_word.restart), ovf_r,
    "overflow not recorded")
  `NGL_CHECK_NOW(a_zero_miss, out_valid_r && !out_word_r.found,
    out_word_r.nearest_greater == '0, "miss with nonzero value")

endmodule

// ===== src/nglstk_cell.sv =====
`timescale 1ns / 1ps
// one stack cell: holds one value and shifts with its neighbors
// depends on nglstk_pkg
module nglstk_cell (
  input  logic                                clk,
  input  nglstk_pkg::shift_ctl_t              ctl,
  input  logic signed [nglstk_pkg::VALUE_W-1:0] from_top,
  input  logic signed [nglstk_pkg::VALUE_W-1:0] from_bottom,
  output logic signed [nglstk_pkg::VALUE_W-1:0] q
);
  import nglstk_pkg::*;

  logic signed [VALUE_W-1:0] q_r;

  // push moves values away from the top, pop pulls them back
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      q_r <= from_top;
    end else if (ctl.pop) begin
      q_r <= from_bottom;
    end
  end

  assign q = q_r;

endmodule

// ===== tb/nearest_greater_left_stack_test.sv =====
`timescale 1ns / 1ps
// self-checking bench for nearest_greater_left_stack: directed and random sequences with
// its own stack predictor, random idling on both sides; needs nglstk_pkg and the design
module nearest_greater_left_stack_test;
  import nglstk_pkg::*;

  localparam int ITEM_TARGET = 1350;
  localparam int CYCLE_LIMIT = 800000;
  localparam int HOLD_CYCLES = 400;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  nearest_greater_left_stack uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  in_word_t                  pending_words[$];
  out_word_t                 expected_answers[$];
  logic signed [VALUE_W-1:0] history[$];
  bit                        history_lost;
  int                        error_count;
  int                        answers_seen;
  int                        cycle_count;
  bit                        in_taken;
  bit                        calm;
  int                        send_gap;
  int                        stall_left;
  int                        hold_left;
  bit                        hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    out_stall = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // mostly no idling, some short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // monotonic decreasing stack; the back of the queue is the top
  task automatic predict_nearest(input in_word_t w);
    out_word_t                 ans;
    logic signed [VALUE_W-1:0] v;
    v = $signed(w.sample);
    if (w.restart) begin
      history.delete();
      history_lost = 1'b0;
    end
    while (history.size() > 0 && $signed(history[$]) <= v)
      void'(history.pop_back());
    ans.found           = (history.size() > 0);
    ans.nearest_greater = ans.found ? history[$] : '0;
    if (history.size() >= STACK_DEPTH) begin
      void'(history.pop_front());
      history_lost = 1'b1;
    end
    history = {history, v};
    ans.truncated = history_lost;
    expected_answers = {expected_answers, ans};
  endtask

  task automatic add_word(input logic signed [VALUE_W-1:0] s, input bit rs);
    in_word_t w;
    w.sample  = s;
    w.restart = rs;
    pending_words = {pending_words, w};
  endtask

  // stimulus
  initial begin
    int                        kind;
    int                        len;
    int                        step;
    logic signed [VALUE_W-1:0] val;
    bit                        rs;

    // directed: empty stack, equal values, extremes, restart
    add_word(0, 1'b1);
    add_word(5, 1'b0);
    add_word(3, 1'b0);
    add_word(3, 1'b0);
    add_word(7, 1'b0);
    add_word(32'sh7fffffff, 1'b0);
    add_word(32'sh80000000, 1'b0);
    add_word(-1, 1'b0);
    add_word(-1, 1'b0);
    add_word(0, 1'b0);
    add_word(32'sh7fffffff, 1'b0);
    add_word(32'sh7fffffff, 1'b0);
    add_word(32'sh80000000, 1'b1);
    add_word(32'sh80000000, 1'b0);
    add_word(-1, 1'b1);
    add_word(32'sh80000000, 1'b0);
    add_word(32'sh55555555, 1'b0);
    add_word(32'sh2aaaaaaa, 1'b0);
    add_word(32'sh55555555, 1'b0);
    add_word(32'sh7ffffffe, 1'b1);

    while (pending_words.size() < ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      rs   = ($urandom_range(0, 9) != 0);
      if (kind < 25) begin
        // full-range values
        len = $urandom_range(5, 40);
        for (int i = 0; i < len; i++) begin
          add_word($urandom(), rs);
          rs = ($urandom_range(0, 49) == 0);
        end
      end else if (kind < 50) begin
        // narrow range, many equal values
        len = $urandom_range(5, 40);
        for (int i = 0; i < len; i++) begin
          add_word($signed($urandom_range(0, 8)) - 4, rs);
          rs = ($urandom_range(0, 49) == 0);
        end
      end else if (kind < 68) begin
        // long falling run that can overflow the stack, then maybe one big value
        len  = $urandom_range(60, 140);
        step = $urandom_range(1, 1000);
        val  = $signed($urandom_range(0, 32'h3fffffff));
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 19) == 0)
            add_word(val + $signed($urandom_range(0, 3 * step)), rs);
          else
            add_word(val, rs);
          val = val - step;
          rs  = 1'b0;
        end
        if ($urandom_range(0, 1) == 0)
          add_word($urandom_range(0, 1) ? 32'sh7fffffff : val + 2 * len * step, 1'b0);
      end else begin
        // sawtooth: falling ramps broken by rises
        len = $urandom_range(10, 60);
        val = $signed($urandom());
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 6) == 0)
            val = val + $signed($urandom_range(0, 5000));
          else
            val = val - $signed($urandom_range(0, 300));
          add_word(val, rs);
          rs = ($urandom_range(0, 49) == 0);
        end
      end
    end
  end

  // cycle counter, timeout and calm stretches
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 256 == 0)
      calm = ($urandom_range(0, 3) == 0);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // acceptance, prediction and result check at the rising edge
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken)
      predict_nearest(in_word);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_answers.size() == 0) begin
        $error("result word with no expectation pending");
        error_count++;
      end else begin
        out_word_t exp_w;
        exp_w = expected_answers.pop_front();
        answers_seen++;
        if (out_word.found !== exp_w.found) begin
          $error("found: expected %0d, got %0d", exp_w.found, out_word.found);
          error_count++;
        end
        if (out_word.nearest_greater !== exp_w.nearest_greater) begin
          $error("nearest_greater: expected %0d, got %0d",
                 exp_w.nearest_greater, out_word.nearest_greater);
          error_count++;
        end
        if (out_word.truncated !== exp_w.truncated) begin
          $error("truncated: expected %0d, got %0d", exp_w.truncated, out_word.truncated);
          error_count++;
        end
      end
    end
  end

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (in_valid && !in_taken) begin
      // hold the stalled word
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_words.size() > 0) begin
      in_word  <= pending_words.pop_front();
      in_valid <= 1'b1;
      send_gap <= idle_len();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver, with one long hold-off to fill the block
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && answers_seen >= 300) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= idle_len();
    end
  end

  // end of run
  initial begin
    error_count  = 0;
    answers_seen = 0;
    cycle_count  = 0;
    in_taken     = 1'b0;
    calm         = 1'b0;
    history_lost = 1'b0;
    wait (rst_n === 1'b1);
    wait (pending_words.size() == 0 && in_valid === 1'b0);
    wait (expected_answers.size() == 0);
    repeat (100) @(posedge clk);
    if (error_count == 0 && expected_answers.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
